>>> rtl/priority_sorted_entry_table_defines.svh
// Assertion macros used by the checker file of the sorted entry table.
// No dependencies; included by bare file name.
`ifndef PRIORITY_SORTED_ENTRY_TABLE_DEFINES_SVH
`define PRIORITY_SORTED_ENTRY_TABLE_DEFINES_SVH

// Property checked on every rising edge, ignored while reset is held.
`define PSTE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define PSTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/pste_pkg.sv
// Shared types and constants of the sorted entry table.
// No dependencies; used by every module of the block.
package pste_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

    // Result queue: two slots so a new item is taken while a result waits.
    localparam int OUTQ_DEPTH  = 2;
    localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);

    // Item kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic signed [31:0] priority_req;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] rot_pitch;
        logic [31:0] rot_yaw;
        logic [31:0] rot_roll;
        logic [3:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_priority;
        logic [31:0] out_pos_x;
        logic [31:0] out_pos_y;
        logic [31:0] out_pos_z;
        logic [31:0] out_pitch;
        logic [31:0] out_yaw;
        logic [31:0] out_roll;
        logic [4:0]  entry_count;
        logic        hit;
        logic        dropped;
    } t_out_item;

    // One stored table entry
    typedef struct packed {
        logic signed [31:0] prio;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] pitch;
        logic [31:0] yaw;
        logic [31:0] roll;
    } t_entry;

    // Per-cell control from the table controller
    typedef struct packed {
        logic ins;  // insert transfer this cycle
        logic occ;  // cell holds a live entry
    } t_cell_ctl;

endpackage

>>> rtl/pste_cell.sv
// One cell of the sorted entry chain: holds one entry, compares it with
// the incoming priority and shifts from its lower neighbor. Uses pste_pkg.
module pste_cell (
    input  logic                i_clk,
    input  pste_pkg::t_cell_ctl i_ctl,
    input  logic                i_prev_go,
    input  pste_pkg::t_entry    i_prev_entry,
    input  pste_pkg::t_entry    i_new_entry,
    output logic                o_go,
    output pste_pkg::t_entry    o_entry
);
    import pste_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // Live entry that sorts at or before the new one stays put
    assign o_go    = i_ctl.occ && ($signed(r_entry.prio) <= $signed(i_new_entry.prio));
    assign o_entry = r_entry;

    // First cell past the prefix takes the new entry, the rest shift up
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && !o_go) begin
            n_entry = i_prev_go ? i_new_entry : i_prev_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> rtl/pste_outq.sv
// Two-slot result queue between the table and the output channel.
// Uses pste_pkg for the result type and queue sizes.
module pste_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pste_pkg::t_out_item i_data,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output pste_pkg::t_out_item o_data
);
    import pste_pkg::*;

    t_out_item             r_slot [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr;
    logic [OUTQ_PTR_W-1:0] r_rd;
    logic [OUTQ_CNT_W-1:0] r_cnt;
    logic                  w_pop;

    assign o_full  = (r_cnt == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_slot[r_rd];
    assign w_pop   = o_valid && !i_stall;

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

>>> rtl/priority_sorted_entry_table.sv
// Sorted entry table top level: chain of entry cells, fill count and
// result queue. Uses pste_pkg, pste_cell and pste_outq.
//
// Usage:
//   Input channel i_valid / o_stall / i_item carries insert and read items.
//   Output channel o_valid / i_stall / o_result carries one result per item.
//   An insert places the entry after every stored entry of lower or equal
//   priority; ties keep arrival order. Inserting into a full table leaves it
//   unchanged and sets dropped. A read returns the entry at read_index with
//   hit set, or zeros and hit clear when the index is past the entry count.
// Timing:
//   One item is taken per cycle while o_stall is low. Every cell compares its
//   priority with the new one in the same cycle and the chain shifts once, so
//   the table is updated at the transfer edge. The result shows on o_result
//   in the cycle after the input transfer when the queue is empty.
//   A two-slot result queue parts the channels: o_stall rises only when both
//   slots hold results the receiver has not taken.
// Reset:
//   Synchronous, active low. The table empties and the queue is cleared;
//   stored words are not cleared, only the entry count.
module priority_sorted_entry_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pste_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output pste_pkg::t_out_item o_result
);
    import pste_pkg::*;

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic              w_accept;
    logic              w_full;
    logic              w_ins;
    logic              w_q_full;
    logic              w_hit;
    t_entry            w_new;
    t_entry            w_rd_entry;
    t_out_item         w_res;
    logic              w_go    [TABLE_DEPTH];
    t_entry            w_entry [TABLE_DEPTH];

    assign o_stall  = w_q_full;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_fill == FILL_W'(TABLE_DEPTH));
    assign w_ins    = w_accept && (i_item.kind == KIND_INSERT) && !w_full;

    assign w_new.prio  = i_item.priority_req;
    assign w_new.pos_x = i_item.pos_x;
    assign w_new.pos_y = i_item.pos_y;
    assign w_new.pos_z = i_item.pos_z;
    assign w_new.pitch = i_item.rot_pitch;
    assign w_new.yaw   = i_item.rot_yaw;
    assign w_new.roll  = i_item.rot_roll;

    // Cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_cell_ctl w_ctl;
        logic      w_prev_go;
        t_entry    w_prev_entry;

        assign w_ctl.ins = w_ins;
        assign w_ctl.occ = (FILL_W'(g) < r_fill);

        if (g == 0) begin : g_head
            assign w_prev_go    = 1'b1;
            assign w_prev_entry = w_new;
        end else begin : g_body
            assign w_prev_go    = w_go[g-1];
            assign w_prev_entry = w_entry[g-1];
        end

        pste_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_prev_go    (w_prev_go),
            .i_prev_entry (w_prev_entry),
            .i_new_entry  (w_new),
            .o_go         (w_go[g]),
            .o_entry      (w_entry[g])
        );
    end

    // Entry count
    assign n_fill = w_ins ? (r_fill + 1'b1) : r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Read select and result build
    assign w_hit      = (32'(i_item.read_index) < 32'(r_fill));
    assign w_rd_entry = w_entry[IDX_W'(i_item.read_index)];

    always_comb begin
        w_res             = '0;
        w_res.entry_count = 5'(n_fill);
        if (i_item.kind == KIND_READ) begin
            if (w_hit) begin
                w_res.out_priority = w_rd_entry.prio;
                w_res.out_pos_x    = w_rd_entry.pos_x;
                w_res.out_pos_y    = w_rd_entry.pos_y;
                w_res.out_pos_z    = w_rd_entry.pos_z;
                w_res.out_pitch    = w_rd_entry.pitch;
                w_res.out_yaw      = w_rd_entry.yaw;
                w_res.out_roll     = w_rd_entry.roll;
                w_res.hit          = 1'b1;
            end
        end else begin
            w_res.dropped = w_full;
        end
    end

    pste_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_res),
        .o_full  (w_q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_result)
    );

endmodule

>>> rtl/pste_chk.sv
// Port-level checker for the sorted entry table, bound to the top level.
// Uses pste_pkg and priority_sorted_entry_table_defines.svh.
`include "priority_sorted_entry_table_defines.svh"

module pste_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input pste_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input pste_pkg::t_out_item o_result
);
    import pste_pkg::*;

    // Held result stays put
    `PSTE_ASSERT(a_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_result)), "result changed while stalled")

    // Nothing pending and input open once reset has been applied
    `PSTE_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> (!o_valid && !o_stall), "channel busy after reset")

    // Entry count never falls between successive results
    `PSTE_ASSERT(a_count, i_clk, i_rst_n, (o_valid && !i_stall) |=> (!o_valid || (o_result.entry_count >= $past(o_result.entry_count))), "entry count decreased")

    // A refused insert only happens at a full table
    `PSTE_ASSERT(a_drop, i_clk, i_rst_n, (o_valid && o_result.dropped) |-> (o_result.entry_count == 5'(TABLE_DEPTH) && !o_result.hit), "drop without full table")

endmodule

bind priority_sorted_entry_table pste_chk u_pste_chk (.*);

>>> bench/entry_table_checker.sv
// Checker for the sorted entry table: watches both channels, keeps its own
// copy of the sorted table and compares every result transfer in order.
// Depends on pste_pkg for the item, result and entry types.
module entry_table_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  pste_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  pste_pkg::t_out_item i_out_result,
    output int                  o_fail_count,
    output int                  o_pending
);
    import pste_pkg::*;

    // Shadow copy of the table, ascending priority, ties in arrival order
    t_entry    sorted_entries [TABLE_DEPTH];
    int        stored_count;
    t_out_item expected_results [$];
    int        mismatches;

    initial begin
        stored_count = 0;
        mismatches   = 0;
    end

    // Apply one item to the shadow table and build the result it should give
    function automatic t_out_item apply_item(input t_in_item item);
        t_out_item res;
        int        slot;
        int        k;
        res = '0;
        if (item.kind == KIND_INSERT) begin
            if (stored_count >= TABLE_DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                // New entry lands after every stored entry of lower or equal priority
                slot = 0;
                while (slot < stored_count &&
                       $signed(sorted_entries[slot].prio) <= $signed(item.priority_req))
                    slot++;
                for (k = stored_count; k > slot; k--)
                    sorted_entries[k] = sorted_entries[k - 1];
                sorted_entries[slot] = '{prio:  item.priority_req,
                                         pos_x: item.pos_x,
                                         pos_y: item.pos_y,
                                         pos_z: item.pos_z,
                                         pitch: item.rot_pitch,
                                         yaw:   item.rot_yaw,
                                         roll:  item.rot_roll};
                stored_count++;
            end
        end else if (item.read_index < stored_count) begin
            res.out_priority = sorted_entries[item.read_index].prio;
            res.out_pos_x    = sorted_entries[item.read_index].pos_x;
            res.out_pos_y    = sorted_entries[item.read_index].pos_y;
            res.out_pos_z    = sorted_entries[item.read_index].pos_z;
            res.out_pitch    = sorted_entries[item.read_index].pitch;
            res.out_yaw      = sorted_entries[item.read_index].yaw;
            res.out_roll     = sorted_entries[item.read_index].roll;
            res.hit          = 1'b1;
        end
        res.entry_count = 5'(stored_count);
        return res;
    endfunction

    function automatic int field_mismatch(input string field_name,
                                          input logic [31:0] exp_val,
                                          input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected %0h, got %0h", field_name, exp_val, got_val);
            return 1;
        end
        return 0;
    endfunction

    function automatic int compare_result(input t_out_item exp_res, input t_out_item got_res);
        int errs;
        errs = 0;
        errs += field_mismatch("out_priority", exp_res.out_priority, got_res.out_priority);
        errs += field_mismatch("out_pos_x", exp_res.out_pos_x, got_res.out_pos_x);
        errs += field_mismatch("out_pos_y", exp_res.out_pos_y, got_res.out_pos_y);
        errs += field_mismatch("out_pos_z", exp_res.out_pos_z, got_res.out_pos_z);
        errs += field_mismatch("out_pitch", exp_res.out_pitch, got_res.out_pitch);
        errs += field_mismatch("out_yaw", exp_res.out_yaw, got_res.out_yaw);
        errs += field_mismatch("out_roll", exp_res.out_roll, got_res.out_roll);
        errs += field_mismatch("entry_count", 32'(exp_res.entry_count),
                               32'(got_res.entry_count));
        errs += field_mismatch("hit", 32'(exp_res.hit), 32'(got_res.hit));
        errs += field_mismatch("dropped", 32'(exp_res.dropped), 32'(got_res.dropped));
        return errs;
    endfunction

    // Result transfers are checked before the same edge's input transfer is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_results.delete();
            stored_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expected result (entry_count %0d)",
                           i_out_result.entry_count);
                    mismatches++;
                end else begin
                    mismatches += compare_result(expected_results.pop_front(), i_out_result);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_item(i_in_item));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> bench/priority_sorted_entry_table_test.sv
// Top of the sorted entry table bench: clock, reset, item stimulus, receiver
// stall pattern, watchdog and verdict. Uses pste_pkg, the block and
// entry_table_checker.
module priority_sorted_entry_table_test;
    import pste_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int HOLD_AT_ITEM   = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    localparam logic signed [31:0] PRIO_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] PRIO_MAX = 32'sh7FFF_FFFF;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_result;
    logic      hold_req  = 1'b0;
    int        burst_left  = 0;
    int        idle_cycles = 0;
    int        fail_count;
    int        pending;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    priority_sorted_entry_table u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_valid  (in_valid),
        .o_stall  (in_stall),
        .i_item   (in_item),
        .o_valid  (out_valid),
        .i_stall  (out_stall),
        .o_result (out_result)
    );

    entry_table_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_result (out_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Extremes and small clustered values give plenty of ties
    function automatic logic signed [31:0] random_priority();
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return PRIO_MIN;
                    1:       return PRIO_MAX;
                    2:       return -1;
                    3:       return 0;
                    default: return 1;
                endcase
            end
            1:       return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_item(input logic kind);
        t_in_item item;
        item.kind         = kind;
        item.priority_req = random_priority();
        item.pos_x        = $urandom;
        item.pos_y        = $urandom;
        item.pos_z        = $urandom;
        item.rot_pitch    = $urandom;
        item.rot_yaw      = $urandom;
        item.rot_roll     = $urandom;
        item.read_index   = $urandom_range(0, 15);
        return item;
    endfunction

    // Offer one item and return at the edge of its transfer; bursts with gaps
    task automatic send_item(input t_in_item item);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 12);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_read(input logic [3:0] index);
        t_in_item item;
        item            = random_item(KIND_READ);
        item.read_index = index;
        send_item(item);
    endtask

    task automatic send_insert(input logic signed [31:0] prio);
        t_in_item item;
        item              = random_item(KIND_INSERT);
        item.priority_req = prio;
        send_item(item);
    endtask

    // Receiver stall: random modes of random length, plus one long hold-off
    initial begin
        t_stall_mode mode;
        int          mode_left;
        bit          hold_done;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Watchdog: too long without a transfer on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("priority_sorted_entry_table regression: fail");
            $finish;
        end
    end

    initial begin
        t_in_item item;
        int       inserts_sent;
        bit       want_insert;
        inserts_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reads of an empty table, extreme priorities, ties, payload extremes
        send_read(4'd0);
        send_read(4'd15);
        item              = random_item(KIND_INSERT);
        item.priority_req = 0;
        item.pos_x        = '1;
        item.pos_y        = '1;
        item.pos_z        = '1;
        item.rot_pitch    = '1;
        item.rot_yaw      = '1;
        item.rot_roll     = '1;
        send_item(item);
        send_insert(PRIO_MIN);
        send_insert(PRIO_MAX);
        send_insert(PRIO_MAX);
        item              = '0;
        item.kind         = KIND_INSERT;
        item.read_index   = '1;
        send_item(item);
        send_insert(-1);
        send_insert(1);
        inserts_sent = 7;
        send_read(4'd0);
        send_read(4'd3);
        send_read(4'd6);
        send_read(4'd7);
        send_read(4'd15);

        // Random: mostly inserts until full, then reads with dropped inserts mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM)
                hold_req <= 1'b1;
            if (inserts_sent < TABLE_DEPTH)
                want_insert = ($urandom_range(0, 9) < 6);
            else
                want_insert = ($urandom_range(0, 3) == 0);
            item = random_item(want_insert ? KIND_INSERT : KIND_READ);
            if (want_insert)
                inserts_sent++;
            send_item(item);
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("priority_sorted_entry_table regression: pass");
        else
            $display("priority_sorted_entry_table regression: fail");
        $finish;
    end

endmodule
